/* rtl/kom_pkg.sv */
// ----------------------------------------------------------------------------
// kom_pkg
// Shared types, pattern table and helpers for the keyword/operator matcher.
// ----------------------------------------------------------------------------
package kom_pkg;

  localparam int WINDOW_BYTES  = 9;
  localparam int PATTERN_COUNT = 37;
  localparam int MAX_PAT_LEN   = 8;
  localparam int MAX_FOLLOW    = 3;
  localparam int CODE_W        = 6;
  localparam int LEN_W         = 4;

  // Input item: window bytes and the remaining byte count
  typedef struct packed {
    logic [7:0] char_0;
    logic [7:0] char_1;
    logic [7:0] char_2;
    logic [7:0] char_3;
    logic [7:0] char_4;
    logic [7:0] char_5;
    logic [7:0] char_6;
    logic [7:0] char_7;
    logic [7:0] char_8;
    logic [3:0] avail_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              matched;
    logic [CODE_W-1:0] symbol_code;
    logic [LEN_W-1:0]  match_length;
  } out_item_t;

  // Window bytes, element 0 at the scan position
  typedef logic [0:WINDOW_BYTES-1][7:0] win_t;

  // One pattern: text left-aligned, allowed follow bytes (none for operators)
  typedef struct packed {
    logic [0:MAX_PAT_LEN-1][7:0] text;
    logic [LEN_W-1:0]            len;
    logic [0:MAX_FOLLOW-1][7:0]  follow;
    logic [1:0]                  fol_cnt;
  } pat_t;

  // Symbol codes in priority order
  typedef enum logic [CODE_W-1:0] {
    SYM_INT, SYM_VOID, SYM_IF, SYM_ELSE, SYM_WHILE, SYM_FOR, SYM_BREAK,
    SYM_CONTINUE, SYM_RETURN,
    SYM_AND_AND, SYM_OR_OR, SYM_INC, SYM_DEC, SYM_ADD_EQ, SYM_SUB_EQ,
    SYM_MUL_EQ, SYM_DIV_EQ, SYM_MOD_EQ, SYM_EQ_EQ, SYM_NOT_EQ, SYM_LE, SYM_GE,
    SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_PERCENT, SYM_LT, SYM_GT,
    SYM_BANG, SYM_ASSIGN, SYM_COMMA, SYM_SEMI, SYM_LPAREN, SYM_RPAREN,
    SYM_LBRACE, SYM_RBRACE
  } sym_e;

  // Pattern table lookup by symbol code
  function automatic pat_t pat_lookup(input logic [CODE_W-1:0] code);
    pat_t p;
    p = '0;
    case (sym_e'(code))
      SYM_INT:      p = '{text: {"int",      40'h0}, len: 4'd3,
                          follow: {" ",   16'h0}, fol_cnt: 2'd1};
      SYM_VOID:     p = '{text: {"void",     32'h0}, len: 4'd4,
                          follow: {" )",   8'h0}, fol_cnt: 2'd2};
      SYM_IF:       p = '{text: {"if",       48'h0}, len: 4'd2,
                          follow: {"( ",   8'h0}, fol_cnt: 2'd2};
      SYM_ELSE:     p = '{text: {"else",     32'h0}, len: 4'd4,
                          follow: "{; ",          fol_cnt: 2'd3};
      SYM_WHILE:    p = '{text: {"while",    24'h0}, len: 4'd5,
                          follow: {"( ",   8'h0}, fol_cnt: 2'd2};
      SYM_FOR:      p = '{text: {"for",      40'h0}, len: 4'd3,
                          follow: {"( ",   8'h0}, fol_cnt: 2'd2};
      SYM_BREAK:    p = '{text: {"break",    24'h0}, len: 4'd5,
                          follow: {"; ",   8'h0}, fol_cnt: 2'd2};
      SYM_CONTINUE: p = '{text: "continue",          len: 4'd8,
                          follow: {"; ",   8'h0}, fol_cnt: 2'd2};
      SYM_RETURN:   p = '{text: {"return",   16'h0}, len: 4'd6,
                          follow: {" ",   16'h0}, fol_cnt: 2'd1};
      SYM_AND_AND:  p = '{text: {"&&", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_OR_OR:    p = '{text: {"||", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_INC:      p = '{text: {"++", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_DEC:      p = '{text: {"--", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_ADD_EQ:   p = '{text: {"+=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_SUB_EQ:   p = '{text: {"-=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_MUL_EQ:   p = '{text: {"*=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_DIV_EQ:   p = '{text: {"/=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_MOD_EQ:   p = '{text: {"%=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_EQ_EQ:    p = '{text: {"==", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_NOT_EQ:   p = '{text: {"!=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_LE:       p = '{text: {"<=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_GE:       p = '{text: {">=", 48'h0}, len: 4'd2, follow: '0, fol_cnt: 2'd0};
      SYM_PLUS:     p = '{text: {"+", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_MINUS:    p = '{text: {"-", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_STAR:     p = '{text: {"*", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_SLASH:    p = '{text: {"/", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_PERCENT:  p = '{text: {"%", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_LT:       p = '{text: {"<", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_GT:       p = '{text: {">", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_BANG:     p = '{text: {"!", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_ASSIGN:   p = '{text: {"=", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_COMMA:    p = '{text: {",", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_SEMI:     p = '{text: {";", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_LPAREN:   p = '{text: {"(", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_RPAREN:   p = '{text: {")", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_LBRACE:   p = '{text: {"{", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      SYM_RBRACE:   p = '{text: {"}", 56'h0}, len: 4'd1, follow: '0, fol_cnt: 2'd0};
      default:      p = '0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/kom_lane.sv */
// ----------------------------------------------------------------------------
// kom_lane
// Tests one pattern against the window: text bytes, length and follow byte.
// ----------------------------------------------------------------------------
module kom_lane (
  input  kom_pkg::win_t          win,
  input  logic [kom_pkg::LEN_W-1:0] avail,
  input  kom_pkg::pat_t          pat,
  output logic                   hit
);

  logic       text_ok;
  logic       follow_ok;
  logic [7:0] next_byte;

  // Compare the pattern text against the window, only up to its length
  always_comb begin
    text_ok = (avail >= pat.len);
    for (int i = 0; i < kom_pkg::MAX_PAT_LEN; i++) begin
      if ((kom_pkg::LEN_W'(i) < pat.len) && (win[i] != pat.text[i])) begin
        text_ok = 1'b0;
      end
    end
  end

  // Check the byte after a keyword against its allowed set
  assign next_byte = win[pat.len];

  always_comb begin
    if (pat.fol_cnt == 2'd0) begin
      follow_ok = 1'b1;
    end else begin
      follow_ok = 1'b0;
      for (int j = 0; j < kom_pkg::MAX_FOLLOW; j++) begin
        if ((2'(j) < pat.fol_cnt) && (next_byte == pat.follow[j])) begin
          follow_ok = 1'b1;
        end
      end
      if (avail <= pat.len) begin
        follow_ok = 1'b0;
      end
    end
  end

  assign hit = text_ok & follow_ok;

endmodule

/* rtl/kom_merge.sv */
// ----------------------------------------------------------------------------
// kom_merge
// Picks the highest-priority lane hit and forms the result item.
// ----------------------------------------------------------------------------
module kom_merge (
  input  logic [kom_pkg::PATTERN_COUNT-1:0] hits,
  output kom_pkg::out_item_t                result
);

  logic                       any_hit;
  logic [kom_pkg::CODE_W-1:0] code;
  kom_pkg::pat_t              pat;

  // Priority encode: lowest lane index wins
  always_comb begin
    any_hit = 1'b0;
    code    = '0;
    for (int k = kom_pkg::PATTERN_COUNT - 1; k >= 0; k--) begin
      if (hits[k]) begin
        any_hit = 1'b1;
        code    = kom_pkg::CODE_W'(k);
      end
    end
  end

  assign pat = kom_pkg::pat_lookup(code);

  // Zero all fields when nothing matched
  always_comb begin
    result.matched      = any_hit;
    result.symbol_code  = any_hit ? code : '0;
    result.match_length = any_hit ? pat.len : '0;
  end

endmodule

/* rtl/keyword_operator_matcher_unit.sv */
// ----------------------------------------------------------------------------
// keyword_operator_matcher_unit
// Recognizes one keyword or operator at the scan position of a text window.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge where start is high; busy stays low,
// so a new window may be issued every cycle. Each result appears on out_item
// for one cycle with out_valid high, in issue order. The receiver cannot stall
// the block and must take each result in that cycle. The item passes two
// register stages: the 37 pattern lanes register their hit flags at the edge
// that takes the item, then the priority merge registers the result at the
// next edge.
module keyword_operator_matcher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kom_pkg::in_item_t  in_item,
  output logic               out_valid,
  output kom_pkg::out_item_t out_item
);

  kom_pkg::win_t                     win;
  logic [kom_pkg::LEN_W-1:0]         avail;
  logic [kom_pkg::PATTERN_COUNT-1:0] hits;
  logic [kom_pkg::PATTERN_COUNT-1:0] hits_r;
  logic                              hit_vld_r;
  kom_pkg::out_item_t                merged;
  logic                              out_valid_r;
  kom_pkg::out_item_t                out_item_r;

  assign busy = 1'b0;

  // Unpack the window and saturate the byte count at the window size
  assign win = {in_item.char_0, in_item.char_1, in_item.char_2,
                in_item.char_3, in_item.char_4, in_item.char_5,
                in_item.char_6, in_item.char_7, in_item.char_8};
  assign avail = (in_item.avail_count > kom_pkg::LEN_W'(kom_pkg::WINDOW_BYTES))
               ? kom_pkg::LEN_W'(kom_pkg::WINDOW_BYTES) : in_item.avail_count;

  // One lane per pattern
  for (genvar k = 0; k < kom_pkg::PATTERN_COUNT; k++) begin : g_lane
    kom_lane u_lane (
      .win   (win),
      .avail (avail),
      .pat   (kom_pkg::pat_lookup(kom_pkg::CODE_W'(k))),
      .hit   (hits[k])
    );
  end

  // Stage 1: hold lane hits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vld_r <= 1'b0;
    end else begin
      hit_vld_r <= start;
    end
    hits_r <= hits;
  end

  kom_merge u_merge (
    .hits   (hits_r),
    .result (merged)
  );

  // Stage 2: hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hit_vld_r;
    end
    out_item_r <= merged;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyword/operator matcher testbench
// Drives nine-byte text windows into the matcher in random bursts and checks
// every token result, field by field and in issue order. A short table of
// hand-picked windows comes first: keywords with and without a legal follow
// byte, windows cut short by the end of text, out-of-range counts and
// all-zero / all-ones bytes. Random windows follow. Most are built around one
// pattern with random context, the rest are source-like or raw byte noise.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTED  = 20;

  // One row of the hand-picked window table
  typedef struct {
    kom_pkg::in_item_t  item;
    bit                 typed;
    kom_pkg::out_item_t want;
  } scan_case_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  kom_pkg::in_item_t  in_item;
  logic               out_valid;
  kom_pkg::out_item_t out_item;

  // Pattern texts in priority order; follow sets are filled in at startup
  string pat_text [kom_pkg::PATTERN_COUNT] = '{
    "int", "void", "if", "else", "while", "for", "break", "continue", "return",
    "&&", "||", "++", "--", "+=", "-=", "*=", "/=", "%=", "==", "!=", "<=", ">=",
    "+", "-", "*", "/", "%", "<", ">", "!", "=", ",", ";", "(", ")", "{", "}"
  };
  string pat_follow [kom_pkg::PATTERN_COUNT];
  string src_chars = "abcdefghilnorstuvw_019 ;(){}+-*/%<>=!,&|";

  scan_case_t         scan_cases [$];
  kom_pkg::out_item_t pending_tokens [$];
  bit                 codes_seen [kom_pkg::PATTERN_COUNT];
  int                 token_errors;
  int                 tokens_checked;
  int                 tokens_matched;
  int                 windows_sent;

  keyword_operator_matcher_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one mismatch line (only the first few) and count it
  task automatic report_mismatch(input string msg);
    if (token_errors < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    token_errors++;
  endtask

  // Pack window bytes and the remaining count into an input item
  function automatic kom_pkg::in_item_t pack_window(input kom_pkg::win_t w,
                                                    input logic [3:0] avail);
    kom_pkg::in_item_t it;
    it.char_0      = w[0];
    it.char_1      = w[1];
    it.char_2      = w[2];
    it.char_3      = w[3];
    it.char_4      = w[4];
    it.char_5      = w[5];
    it.char_6      = w[6];
    it.char_7      = w[7];
    it.char_8      = w[8];
    it.avail_count = avail;
    return it;
  endfunction

  // Predict the token found at the scan position of one window
  function automatic kom_pkg::out_item_t match_token(input kom_pkg::in_item_t it);
    kom_pkg::win_t      w;
    int                 avail;
    int                 plen;
    bit                 hit;
    logic [7:0]         ch;
    kom_pkg::out_item_t tok;
    w     = {it.char_0, it.char_1, it.char_2, it.char_3, it.char_4,
             it.char_5, it.char_6, it.char_7, it.char_8};
    avail = (it.avail_count > 4'd9) ? kom_pkg::WINDOW_BYTES : int'(it.avail_count);
    tok   = '0;
    for (int k = 0; k < kom_pkg::PATTERN_COUNT; k++) begin
      plen = pat_text[k].len();
      if (avail < plen) continue;
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        ch = pat_text[k][i];
        if (w[i] != ch) hit = 1'b0;
      end
      // keywords need a legal byte right after them, inside the text
      if (hit && pat_follow[k].len() != 0) begin
        hit = 1'b0;
        if (avail > plen && plen < kom_pkg::WINDOW_BYTES) begin
          for (int f = 0; f < pat_follow[k].len(); f++) begin
            ch = pat_follow[k][f];
            if (w[plen] == ch) hit = 1'b1;
          end
        end
      end
      if (hit) begin
        tok.matched      = 1'b1;
        tok.symbol_code  = kom_pkg::CODE_W'(k);
        tok.match_length = kom_pkg::LEN_W'(plen);
        return tok;
      end
    end
    return tok;
  endfunction

  // Add a table row: text at the scan position, the rest filled with one byte
  function automatic void add_case(input string s, input logic [7:0] fill,
                                   input logic [3:0] avail, input bit typed,
                                   input logic m, input kom_pkg::sym_e code,
                                   input int len);
    scan_case_t    sc;
    kom_pkg::win_t w;
    for (int i = 0; i < kom_pkg::WINDOW_BYTES; i++) begin
      w[i] = (i < s.len()) ? s[i] : fill;
    end
    sc.item               = pack_window(w, avail);
    sc.typed              = typed;
    sc.want.matched       = m;
    sc.want.symbol_code   = code;
    sc.want.match_length  = kom_pkg::LEN_W'(len);
    scan_cases.push_back(sc);
  endfunction

  // Offer one window and hold it until taken; then queue its expected token
  task automatic send_window(input kom_pkg::in_item_t it, input bit typed,
                             input kom_pkg::out_item_t want);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_tokens.push_back(typed ? want : match_token(it));
    windows_sent++;
  endtask

  // Drop start for a random gap (zero keeps the burst going)
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Check each result against the oldest expected token
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("token result with no window pending");
      end else begin
        kom_pkg::out_item_t want;
        want = pending_tokens.pop_front();
        if (out_item.matched !== want.matched)
          report_mismatch($sformatf("token %0d matched: got %b, expected %b",
                                    tokens_checked, out_item.matched, want.matched));
        if (out_item.symbol_code !== want.symbol_code)
          report_mismatch($sformatf("token %0d symbol_code: got %0d, expected %0d",
                                    tokens_checked, out_item.symbol_code,
                                    want.symbol_code));
        if (out_item.match_length !== want.match_length)
          report_mismatch($sformatf("token %0d match_length: got %0d, expected %0d",
                                    tokens_checked, out_item.match_length,
                                    want.match_length));
        if (want.matched) begin
          codes_seen[want.symbol_code] = 1'b1;
          tokens_matched++;
        end
        tokens_checked++;
      end
    end
  end

  // Main sequence
  initial begin
    kom_pkg::win_t      w;
    kom_pkg::out_item_t none;
    int                 sent;
    int                 burst;
    int                 k;
    int                 plen;
    int                 r;
    int                 avail;
    int                 waited;
    int                 codes_hit;

    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    none           = '0;
    token_errors   = 0;
    tokens_checked = 0;
    tokens_matched = 0;
    windows_sent   = 0;

    for (int i = 0; i < kom_pkg::PATTERN_COUNT; i++) pat_follow[i] = "";
    pat_follow[kom_pkg::SYM_INT]      = " ";
    pat_follow[kom_pkg::SYM_VOID]     = " )";
    pat_follow[kom_pkg::SYM_IF]       = "( ";
    pat_follow[kom_pkg::SYM_ELSE]     = "{; ";
    pat_follow[kom_pkg::SYM_WHILE]    = "( ";
    pat_follow[kom_pkg::SYM_FOR]      = "( ";
    pat_follow[kom_pkg::SYM_BREAK]    = "; ";
    pat_follow[kom_pkg::SYM_CONTINUE] = "; ";
    pat_follow[kom_pkg::SYM_RETURN]   = " ";

    // text, fill byte, count, typed, matched, code, length
    add_case("",          8'h00, 4'd0,  1, 0, kom_pkg::SYM_INT,      0);
    add_case("",          8'hFF, 4'd15, 1, 0, kom_pkg::SYM_INT,      0);
    add_case("int ",      "x",   4'd9,  1, 1, kom_pkg::SYM_INT,      3);
    add_case("int(",      "x",   4'd9,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("int ",      " ",   4'd3,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("void)",     8'h00, 4'd5,  1, 1, kom_pkg::SYM_VOID,     4);
    add_case("if(",       "a",   4'd3,  1, 1, kom_pkg::SYM_IF,       2);
    add_case("else;",     "a",   4'd15, 1, 1, kom_pkg::SYM_ELSE,     4);
    add_case("else{",     "a",   4'd9,  1, 1, kom_pkg::SYM_ELSE,     4);
    add_case("while ",    "b",   4'd6,  1, 1, kom_pkg::SYM_WHILE,    5);
    add_case("for(",      "c",   4'd4,  1, 1, kom_pkg::SYM_FOR,      3);
    add_case("forx",      " ",   4'd9,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("break;",    "z",   4'd9,  1, 1, kom_pkg::SYM_BREAK,    5);
    add_case("continue;", 8'hFF, 4'd9,  1, 1, kom_pkg::SYM_CONTINUE, 8);
    add_case("continue;", 8'hFF, 4'd8,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("return ",   8'h00, 4'd7,  1, 1, kom_pkg::SYM_RETURN,   6);
    add_case("returnx",   " ",   4'd9,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("&&",        8'h00, 4'd2,  1, 1, kom_pkg::SYM_AND_AND,  2);
    add_case("&&",        8'h00, 4'd1,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("+=",        "x",   4'd9,  1, 1, kom_pkg::SYM_ADD_EQ,   2);
    add_case("+=",        "x",   4'd1,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("==",        8'hFF, 4'd1,  0, 0, kom_pkg::SYM_INT,      0);
    add_case("!=",        "=",   4'd12, 0, 0, kom_pkg::SYM_INT,      0);
    add_case("}",         8'h00, 4'd1,  1, 1, kom_pkg::SYM_RBRACE,   1);
    add_case("(",         8'h00, 4'd0,  0, 0, kom_pkg::SYM_INT,      0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table in order, with three short random gaps
    foreach (scan_cases[i]) begin
      send_window(scan_cases[i].item, scan_cases[i].typed, scan_cases[i].want);
      if (i % 9 == 4) idle_gap($urandom_range(1, 3));
    end
    idle_gap(2);

    // Random windows in bursts
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                          : $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        for (int i = 0; i < kom_pkg::WINDOW_BYTES; i++) begin
          w[i] = src_chars[$urandom_range(0, src_chars.len() - 1)];
        end
        plen = 0;
        r    = $urandom_range(0, 99);
        if (r < 60) begin
          // one pattern at the scan position, random context after it
          k    = $urandom_range(0, kom_pkg::PATTERN_COUNT - 1);
          plen = pat_text[k].len();
          for (int i = 0; i < plen; i++) w[i] = pat_text[k][i];
          if (pat_follow[k].len() != 0 && $urandom_range(0, 3) != 0)
            w[plen] = pat_follow[k][$urandom_range(0, pat_follow[k].len() - 1)];
          if ($urandom_range(0, 9) == 0)
            w[$urandom_range(0, plen - 1)] =
              src_chars[$urandom_range(0, src_chars.len() - 1)];
        end else if (r >= 85) begin
          for (int i = 0; i < kom_pkg::WINDOW_BYTES; i++) w[i] = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 50)
          avail = kom_pkg::WINDOW_BYTES;
        else if (r < 60)
          avail = $urandom_range(10, 15);
        else if (r < 85 && plen > 0)
          avail = plen + int'($urandom_range(0, 2)) - 1;
        else
          avail = $urandom_range(0, 8);
        send_window(pack_window(w, 4'(avail)), 1'b0, none);
        sent++;
      end
      idle_gap($urandom_range(0, 6));
    end
    start <= 1'b0;

    // Let the last tokens come out, then watch for strays
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0)
      report_mismatch($sformatf("%0d expected tokens never came out",
                                pending_tokens.size()));

    codes_hit = 0;
    foreach (codes_seen[i]) if (codes_seen[i]) codes_hit++;
    $display("Checked %0d tokens from %0d windows; %0d were keyword/operator hits.",
             tokens_checked, windows_sent, tokens_matched);
    $display("Symbol codes seen: %0d of %0d; %0d mismatches.",
             codes_hit, kom_pkg::PATTERN_COUNT, token_errors);
    if (token_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/kom_pkg.sv
rtl/kom_lane.sv
rtl/kom_merge.sv
rtl/keyword_operator_matcher_unit.sv
tb/tb_top.sv
